// ===== sv/x86d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package x86d_pkg;

  // instruction classes recognised from the opcode byte
  typedef enum logic [3:0] {
    K_NONE        = 4'd0,
    K_RMREG       = 4'd1,
    K_IMMRM_MOV   = 4'd2,
    K_IMMRM_ARITH = 4'd3,
    K_IMMREG      = 4'd4,
    K_MEMACC      = 4'd5,
    K_ACCMEM      = 4'd6,
    K_IMMACC      = 4'd7,
    K_JNZ         = 4'd8
  } kind_e;

  // operation codes on the result
  localparam logic [2:0] OP_MOV = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_CMP = 3'd3;
  localparam logic [2:0] OP_JNZ = 3'd4;

  // operand form codes on the result
  localparam logic [2:0] FM_RM_REG  = 3'd0;
  localparam logic [2:0] FM_IMM_RM  = 3'd1;
  localparam logic [2:0] FM_IMM_REG = 3'd2;
  localparam logic [2:0] FM_MEM_ACC = 3'd3;
  localparam logic [2:0] FM_ACC_MEM = 3'd4;
  localparam logic [2:0] FM_IMM_ACC = 3'd5;
  localparam logic [2:0] FM_JUMP    = 3'd6;

  // opcode patterns
  localparam logic [5:0] OPC6_MOV_RM  = 6'b100010;
  localparam logic [5:0] OPC6_ADD_RM  = 6'b000000;
  localparam logic [5:0] OPC6_SUB_RM  = 6'b001010;
  localparam logic [5:0] OPC6_CMP_RM  = 6'b001110;
  localparam logic [6:0] OPC7_MOV_IRM = 7'b1100011;
  localparam logic [5:0] OPC6_GRP_IRM = 6'b100000;
  localparam logic [3:0] OPC4_MOV_IRG = 4'b1011;
  localparam logic [6:0] OPC7_MEM_ACC = 7'b1010000;
  localparam logic [6:0] OPC7_ACC_MEM = 7'b1010001;
  localparam logic [6:0] OPC7_ADD_IAC = 7'b0000010;
  localparam logic [6:0] OPC7_SUB_IAC = 7'b0010110;
  localparam logic [6:0] OPC7_CMP_IAC = 7'b0011110;
  localparam logic [7:0] OPC8_JNZ     = 8'b01110101;

  // group digits of the immediate arithmetic opcode
  localparam logic [2:0] DIG_ADD = 3'b000;
  localparam logic [2:0] DIG_SUB = 3'b101;
  localparam logic [2:0] DIG_CMP = 3'b111;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         form;
    logic               wide;
    logic               reg_is_dest;
    logic [1:0]         mode;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [2:0]         length;
  } rec_t;

  function automatic kind_e kind_of(input logic [7:0] op);
    kind_e k;
    k = K_NONE;
    if (op[7:2] == OPC6_MOV_RM || op[7:2] == OPC6_ADD_RM ||
        op[7:2] == OPC6_SUB_RM || op[7:2] == OPC6_CMP_RM) k = K_RMREG;
    else if (op[7:1] == OPC7_MOV_IRM) k = K_IMMRM_MOV;
    else if (op[7:2] == OPC6_GRP_IRM) k = K_IMMRM_ARITH;
    else if (op[7:4] == OPC4_MOV_IRG) k = K_IMMREG;
    else if (op[7:1] == OPC7_MEM_ACC) k = K_MEMACC;
    else if (op[7:1] == OPC7_ACC_MEM) k = K_ACCMEM;
    else if (op[7:1] == OPC7_ADD_IAC || op[7:1] == OPC7_SUB_IAC ||
             op[7:1] == OPC7_CMP_IAC) k = K_IMMACC;
    else if (op == OPC8_JNZ) k = K_JNZ;
    return k;
  endfunction

  function automatic logic has_modrm(input kind_e k);
    return (k == K_RMREG) || (k == K_IMMRM_MOV) || (k == K_IMMRM_ARITH);
  endfunction

  function automatic logic [1:0] disp_len(input kind_e k, input logic [7:0] modrm);
    logic [1:0] n;
    n = 2'd0;
    if (has_modrm(k)) begin
      case (modrm[7:6])
        2'd0:    n = (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
        2'd1:    n = 2'd1;
        2'd2:    n = 2'd2;
        default: n = 2'd0;
      endcase
    end else if (k == K_MEMACC || k == K_ACCMEM) begin
      n = 2'd2;
    end else if (k == K_JNZ) begin
      n = 2'd1;
    end
    return n;
  endfunction

  function automatic logic [1:0] data_len(input kind_e k, input logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    if (k == K_IMMRM_MOV || k == K_IMMACC) n = op[0] ? 2'd2 : 2'd1;
    else if (k == K_IMMRM_ARITH) n = (op[0] && !op[1]) ? 2'd2 : 2'd1;
    else if (k == K_IMMREG) n = op[3] ? 2'd2 : 2'd1;
    return n;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== sv/x86d_record.sv =====
`timescale 1ns / 1ps
`default_nettype none

// builds the decoded record from the collected instruction bytes
module x86d_record import x86d_pkg::*; (
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  modrm_i,
  input  logic [15:0] disp_i,
  input  logic [15:0] imm_i,
  input  logic [2:0]  count_i,
  output rec_t        rec_o,
  output logic        rec_ok_o
);

  kind_e      kind;
  logic [1:0] dl;
  logic [1:0] il;

  always_comb begin
    kind     = kind_of(opcode_i);
    dl       = disp_len(kind, modrm_i);
    il       = data_len(kind, opcode_i);
    rec_o    = '0;
    rec_ok_o = 1'b1;

    case (dl)
      2'd1:    rec_o.displacement = sext8(disp_i[7:0]);
      2'd2:    rec_o.displacement = disp_i;
      default: rec_o.displacement = '0;
    endcase
    case (il)
      2'd1:    rec_o.immediate = {8'h00, imm_i[7:0]};
      2'd2:    rec_o.immediate = imm_i;
      default: rec_o.immediate = '0;
    endcase

    if (has_modrm(kind)) begin
      rec_o.mode           = modrm_i[7:6];
      rec_o.reg_field      = modrm_i[5:3];
      rec_o.rm_field       = modrm_i[2:0];
      rec_o.wide           = opcode_i[0];
      rec_o.direct_address = (modrm_i[7:6] == 2'd0) && (modrm_i[2:0] == 3'd6);
    end

    case (kind)
      K_RMREG: begin
        if (opcode_i[7:2] == OPC6_MOV_RM) rec_o.operation = OP_MOV;
        else if (opcode_i[7:2] == OPC6_ADD_RM) rec_o.operation = OP_ADD;
        else if (opcode_i[7:2] == OPC6_SUB_RM) rec_o.operation = OP_SUB;
        else rec_o.operation = OP_CMP;
        rec_o.form        = FM_RM_REG;
        rec_o.reg_is_dest = opcode_i[1];
      end
      K_IMMRM_MOV: begin
        rec_o.operation = OP_MOV;
        rec_o.form      = FM_IMM_RM;
      end
      K_IMMRM_ARITH: begin
        if (modrm_i[5:3] == DIG_ADD) rec_o.operation = OP_ADD;
        else if (modrm_i[5:3] == DIG_SUB) rec_o.operation = OP_SUB;
        else if (modrm_i[5:3] == DIG_CMP) rec_o.operation = OP_CMP;
        else rec_ok_o = 1'b0;
        rec_o.form = FM_IMM_RM;
        // single data byte with s and w set is sign-extended
        if (il == 2'd1 && opcode_i[0] && opcode_i[1]) rec_o.immediate = sext8(imm_i[7:0]);
      end
      K_IMMREG: begin
        rec_o.operation   = OP_MOV;
        rec_o.form        = FM_IMM_REG;
        rec_o.wide        = opcode_i[3];
        rec_o.reg_is_dest = 1'b1;
        rec_o.reg_field   = opcode_i[2:0];
      end
      K_MEMACC: begin
        rec_o.operation   = OP_MOV;
        rec_o.form        = FM_MEM_ACC;
        rec_o.wide        = opcode_i[0];
        rec_o.reg_is_dest = 1'b1;
      end
      K_ACCMEM: begin
        rec_o.operation = OP_MOV;
        rec_o.form      = FM_ACC_MEM;
        rec_o.wide      = opcode_i[0];
      end
      K_IMMACC: begin
        if (opcode_i[7:1] == OPC7_ADD_IAC) rec_o.operation = OP_ADD;
        else if (opcode_i[7:1] == OPC7_SUB_IAC) rec_o.operation = OP_SUB;
        else rec_o.operation = OP_CMP;
        rec_o.form        = FM_IMM_ACC;
        rec_o.wide        = opcode_i[0];
        rec_o.reg_is_dest = 1'b1;
      end
      K_JNZ: begin
        rec_o.operation = OP_JNZ;
        rec_o.form      = FM_JUMP;
      end
      default: rec_ok_o = 1'b0;
    endcase

    rec_o.length = count_i;
  end

endmodule

`default_nettype wire

// ===== sv/x86_16bit_instruction_decoder_unit.sv =====
// 8086 decoder: one byte transaction accepted per cycle while in_ready_o is high, no bubbles between instructions
// the record is registered and appears on the output in the cycle after the last byte of its instruction is accepted
// the byte sequencer updates its state on each accepted byte
// rst_ni is asynchronous, active low; it returns the sequencer to the opcode phase
// and clears the output valid flag; the record payload itself is not reset
`timescale 1ns / 1ps
`default_nettype none

module x86_16bit_instruction_decoder_unit import x86d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte stream
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  // decoded records
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         operation_o,
  output logic [2:0]         form_o,
  output logic               wide_o,
  output logic               reg_is_dest_o,
  output logic [1:0]         mode_o,
  output logic [2:0]         reg_field_o,
  output logic [2:0]         rm_field_o,
  output logic               direct_address_o,
  output logic signed [15:0] displacement_o,
  output logic [15:0]        immediate_o,
  output logic [2:0]         length_o
);

  // byte sequencer phases
  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_MODRM  = 2'd1,
    PH_DISP   = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [1:0]  disp_left_q, disp_left_d;
  logic [1:0]  data_left_q, data_left_d;
  logic [15:0] disp_q, disp_d;
  logic [15:0] imm_q, imm_d;
  logic [2:0]  count_q, count_d;

  logic        out_valid_q, out_valid_d;
  rec_t        rec_q;

  logic        accept;
  logic        take_opcode;
  logic        advance;
  logic        finish;
  kind_e       kind_cur;
  kind_e       kind_new;
  logic        pos;

  rec_t        rec_new;
  logic        rec_ok;

  // the output register frees itself in the same cycle it is read
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // sequencer next state, as seen after the current byte
  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    modrm_d     = modrm_q;
    disp_left_d = disp_left_q;
    data_left_d = data_left_q;
    disp_d      = disp_q;
    imm_d       = imm_q;
    count_d     = count_q;
    take_opcode = 1'b0;
    advance     = 1'b0;
    finish      = 1'b0;
    pos         = 1'b0;
    kind_cur    = kind_of(opcode_q);
    kind_new    = kind_of(data_byte_i);

    if (accept) begin
      case (phase_q)
        PH_MODRM: begin
          modrm_d     = data_byte_i;
          count_d     = count_q + 3'd1;
          disp_left_d = disp_len(kind_cur, data_byte_i);
          data_left_d = data_len(kind_cur, opcode_q);
          advance     = 1'b1;
        end
        PH_DISP: begin
          if (disp_left_q != 2'd0) begin
            // low byte first
            pos = disp_len(kind_cur, modrm_q) - disp_left_q == 2'd1;
            if (pos) disp_d[15:8] = disp_q[15:8] | data_byte_i;
            else disp_d[7:0] = disp_q[7:0] | data_byte_i;
            disp_left_d = disp_left_q - 2'd1;
            count_d     = count_q + 3'd1;
            advance     = 1'b1;
          end else begin
            take_opcode = 1'b1;
          end
        end
        PH_DATA: begin
          if (data_left_q != 2'd0) begin
            pos = data_len(kind_cur, opcode_q) - data_left_q == 2'd1;
            if (pos) imm_d[15:8] = imm_q[15:8] | data_byte_i;
            else imm_d[7:0] = imm_q[7:0] | data_byte_i;
            data_left_d = data_left_q - 2'd1;
            count_d     = count_q + 3'd1;
            advance     = 1'b1;
          end else begin
            take_opcode = 1'b1;
          end
        end
        default: take_opcode = 1'b1;
      endcase

      if (take_opcode) begin
        phase_d = PH_OPCODE;
        // unknown opcodes are skipped and leave the rest untouched
        if (kind_new != K_NONE) begin
          opcode_d    = data_byte_i;
          modrm_d     = '0;
          disp_d      = '0;
          imm_d       = '0;
          count_d     = 3'd1;
          disp_left_d = '0;
          data_left_d = '0;
          if (has_modrm(kind_new)) begin
            phase_d = PH_MODRM;
          end else begin
            disp_left_d = disp_len(kind_new, 8'h00);
            data_left_d = data_len(kind_new, data_byte_i);
            advance     = 1'b1;
          end
        end
      end

      if (advance) begin
        if (disp_left_d != 2'd0) begin
          phase_d = PH_DISP;
        end else if (data_left_d != 2'd0) begin
          phase_d = PH_DATA;
        end else begin
          phase_d = PH_OPCODE;
          finish  = 1'b1;
        end
      end
    end
  end

  // record formed from the state as it will be after this byte
  x86d_record u_record (
    .opcode_i (opcode_d),
    .modrm_i  (modrm_d),
    .disp_i   (disp_d),
    .imm_i    (imm_d),
    .count_i  (count_d),
    .rec_o    (rec_new),
    .rec_ok_o (rec_ok)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish && rec_ok) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPCODE;
      opcode_q    <= '0;
      modrm_q     <= '0;
      disp_left_q <= '0;
      data_left_q <= '0;
      disp_q      <= '0;
      imm_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      opcode_q    <= opcode_d;
      modrm_q     <= modrm_d;
      disp_left_q <= disp_left_d;
      data_left_q <= data_left_d;
      disp_q      <= disp_d;
      imm_q       <= imm_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only when a record completes
  always_ff @(posedge clk_i) begin
    if (finish && rec_ok) begin
      rec_q <= rec_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign operation_o      = rec_q.operation;
  assign form_o           = rec_q.form;
  assign wide_o           = rec_q.wide;
  assign reg_is_dest_o    = rec_q.reg_is_dest;
  assign mode_o           = rec_q.mode;
  assign reg_field_o      = rec_q.reg_field;
  assign rm_field_o       = rec_q.rm_field;
  assign direct_address_o = rec_q.direct_address;
  assign displacement_o   = rec_q.displacement;
  assign immediate_o      = rec_q.immediate;
  assign length_o         = rec_q.length;

endmodule

`default_nettype wire
